// ===== sv/button_encoder_key_event_decoder_macros.svh =====
// Assertion helpers for the key event decoder.
`ifndef BUTTON_ENCODER_KEY_EVENT_DECODER_MACROS_SVH
`define BUTTON_ENCODER_KEY_EVENT_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BEKD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bekd assertion failed");

// Next-cycle implication, disabled while reset is held.
`define BEKD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bekd assertion failed");

`endif

// ===== sv/bekd_pkg.sv =====
package bekd_pkg;

    localparam int KEY_W  = 8;
    localparam int TS_W   = 32;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] DELAY_RESET_MS = CFG_W'(500);
    localparam logic [KEY_W-1:0] KEYS_NONE      = 8'h00;

    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 1'b1;

    localparam logic [KEY_W-1:0] EV_UP   = 8'h01;
    localparam logic [KEY_W-1:0] EV_DOWN = 8'h02;
    localparam logic [KEY_W-1:0] EV_OK   = 8'h04;
    localparam logic [KEY_W-1:0] EV_BACK = 8'h08;

    typedef struct packed {
        logic [KEY_W-1:0] key_byte;
        logic             enc_a;
        logic             enc_b;
        logic             enc_key_n;
        logic [TS_W-1:0]  now_ms;
        logic             clear_keys;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0] key_word;
        logic             keys_held;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] repeat_delay_ms;
        logic [CFG_W-1:0] long_press_ms;
    } t_cfg;

    // keypad byte bits to event word bits
    function automatic logic [KEY_W-1:0] remap_keys(input logic [KEY_W-1:0] b);
        logic [KEY_W-1:0] w;
        w = {b[3], b[0], b[2], b[1], b[5], b[6], b[7], b[4]};
        return w;
    endfunction

endpackage

// ===== sv/bekd_in_stage.sv =====
module bekd_in_stage
    import bekd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    input  logic      i_take,
    output logic      o_stall,
    output logic      o_vld,
    output t_in_item  o_item
);

    logic     r_vld;
    logic     n_vld;
    t_in_item r_item;

    assign o_stall = r_vld && !i_take;
    assign o_vld   = r_vld;
    assign o_item  = r_item;

    always_comb begin
        n_vld = r_vld;
        if (i_take) begin
            n_vld = 1'b0;
        end
        if (i_valid && !o_stall) begin
            n_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== sv/bekd_core.sv =====
module bekd_core
    import bekd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_vld,
    input  t_in_item  i_item,
    output logic      o_take,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    logic             r_enc_a_prev;
    logic             r_enc_key_prev;
    logic [TS_W-1:0]  r_long_press_deadline;
    logic             r_pad_held;
    logic [TS_W-1:0]  r_repeat_deadline;
    logic [KEY_W-1:0] r_event_word;
    logic             r_out_vld;
    t_out_item        r_out_item;

    logic             n_long_press_deadline_en;
    logic [TS_W-1:0]  n_long_press_deadline;
    logic             n_pad_held;
    logic             n_repeat_deadline_en;
    logic [TS_W-1:0]  n_repeat_deadline;
    logic [KEY_W-1:0] n_event_word;
    logic             n_out_vld;

    logic             pressed;
    logic             keys_any;
    logic [KEY_W-1:0] remapped;

    assign o_take      = i_vld && (!r_out_vld || !i_out_stall);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    assign pressed  = !i_item.enc_key_n;
    assign keys_any = i_item.key_byte != KEYS_NONE;
    assign remapped = remap_keys(i_item.key_byte);

    assign n_long_press_deadline = i_item.now_ms + TS_W'(i_cfg.long_press_ms);
    assign n_repeat_deadline     = i_item.now_ms + TS_W'(i_cfg.repeat_delay_ms);

    always_comb begin
        n_event_word             = i_item.clear_keys ? KEYS_NONE : r_event_word;
        n_pad_held               = r_pad_held;
        n_long_press_deadline_en = 1'b0;
        n_repeat_deadline_en     = 1'b0;

        if (r_enc_a_prev && !i_item.enc_a) begin
            n_event_word = n_event_word | (i_item.enc_b ? EV_DOWN : EV_UP);
        end

        if (pressed && !r_enc_key_prev) begin
            n_long_press_deadline_en = 1'b1;
        end else if (!pressed && r_enc_key_prev) begin
            if (i_item.now_ms < r_long_press_deadline) begin
                n_event_word = n_event_word | EV_OK;
            end else begin
                n_event_word = n_event_word | EV_BACK;
            end
        end

        if (!r_pad_held && keys_any) begin
            n_event_word         = n_event_word | remapped;
            n_pad_held           = 1'b1;
            n_repeat_deadline_en = 1'b1;
        end else if (r_pad_held && (i_item.now_ms >= r_repeat_deadline) && keys_any) begin
            n_event_word = n_event_word | remapped;
        end else if (r_pad_held && !keys_any) begin
            n_event_word = KEYS_NONE;
            n_pad_held   = 1'b0;
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
        if (o_take) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc_a_prev          <= 1'b0;
            r_enc_key_prev        <= 1'b0;
            r_long_press_deadline <= '0;
            r_pad_held            <= 1'b0;
            r_repeat_deadline     <= '0;
            r_event_word          <= KEYS_NONE;
            r_out_vld             <= 1'b0;
            r_out_item            <= '0;
        end else begin
            r_out_vld <= n_out_vld;
            if (o_take) begin
                r_enc_a_prev   <= i_item.enc_a;
                r_enc_key_prev <= pressed;
                r_pad_held     <= n_pad_held;
                r_event_word   <= n_event_word;
                if (n_long_press_deadline_en) begin
                    r_long_press_deadline <= n_long_press_deadline;
                end
                if (n_repeat_deadline_en) begin
                    r_repeat_deadline <= n_repeat_deadline;
                end
                r_out_item.key_word  <= n_event_word;
                r_out_item.keys_held <= n_pad_held;
            end
        end
    end

endmodule

// ===== sv/button_encoder_key_event_decoder.sv =====
// Rotary encoder and keypad event decoder. Each input item is one sample
// (keypad byte, encoder A/B, active-low encoder key, millisecond timestamp,
// clear flag) and yields exactly one result item: the event word after the
// sample and the keypad-held flag. An item passes an input register and a
// result register, and one item can be taken every cycle while the output
// is not stalled; the event state is updated as each item is taken.
// Deadlines are the timestamp plus the 16-bit delay, wrapping at 32 bits,
// compared unsigned. Configuration writes (index 0 repeat delay, index 1
// long-press time, both 500 after reset) are to be made while no item is
// in flight.
module button_encoder_key_event_decoder
    import bekd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item
);

    t_cfg     r_cfg;
    logic     take;
    logic     stg_vld;
    t_in_item stg_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_delay_ms <= DELAY_RESET_MS;
            r_cfg.long_press_ms   <= DELAY_RESET_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REPEAT_DELAY: begin
                    r_cfg.repeat_delay_ms <= i_cfg_wdata;
                end
                CFG_LONG_PRESS: begin
                    r_cfg.long_press_ms <= i_cfg_wdata;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    bekd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .i_take  (take),
        .o_stall (o_in_stall),
        .o_vld   (stg_vld),
        .o_item  (stg_item)
    );

    bekd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_vld       (stg_vld),
        .i_item      (stg_item),
        .o_take      (take),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== sv/bekd_checker.sv =====
`include "button_encoder_key_event_decoder_macros.svh"

module bekd_checker
    import bekd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    `BEKD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    `BEKD_ASSERT_NOW(a_in_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    `BEKD_ASSERT_NOW(a_no_spurious_out, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && !o_in_stall, 2))
    `BEKD_ASSERT_NOW(a_release_clears, i_clk, i_rst_n, $fell(o_out_item.keys_held), o_out_item.key_word == KEYS_NONE)

endmodule

bind button_encoder_key_event_decoder bekd_checker u_bekd_checker (.*);
